[design/pisp_pkg.sv]
// ----------------------------------------------------------------------------
// pisp_pkg: shared types and constants of the prefixed integer string parser
// Holds the classified character beat, the parse phase encoding, the result
// snapshot and the character and base constants used by several modules.
// ----------------------------------------------------------------------------
package pisp_pkg;

  localparam int VALUE_W     = 64;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 6;
  localparam int PFX_W       = 5;
  localparam int CONSUMED_W  = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_CHARS_DEFAULT = 1023;

  localparam logic [BASE_W-1:0] DEC_BASE = BASE_W'(10);
  localparam logic [PFX_W-1:0]  HEX_BASE = PFX_W'(16);
  localparam logic [PFX_W-1:0]  OCT_BASE = PFX_W'(8);
  localparam logic [PFX_W-1:0]  BIN_BASE = PFX_W'(2);
  localparam logic [PFX_W-1:0]  NO_PFX   = PFX_W'(0);

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO    = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // One character after classification.
  typedef struct packed {
    logic               last;
    logic               is_sign;
    logic               is_minus;
    logic               is_digit;
    logic [DIGIT_W-1:0] dval;
    logic [PFX_W-1:0]   pfx_base;
  } cls_t;

  // State of one finished string, handed to the result stage.
  typedef struct packed {
    logic [VALUE_W-1:0]    magnitude;
    logic                  negative;
    logic                  overflowed;
    logic [CONSUMED_W-1:0] consumed;
  } snap_t;

endpackage

[design/pisp_front.sv]
// ----------------------------------------------------------------------------
// pisp_front: character classifier
// Decodes each incoming byte into sign, digit value and prefix letter and
// pushes the classified beat into the queue.
// ----------------------------------------------------------------------------
module pisp_front import pisp_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_character,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output cls_t              q_wdata
);

  logic [CHAR_W-1:0] lower;

  assign lower = ((in_character >= CH_UA) && (in_character <= CH_UZ)) ?
                 (in_character | CASE_BIT) : in_character;

  always_comb begin
    q_wdata          = '0;
    q_wdata.last     = in_last;
    q_wdata.is_sign  = (in_character == CH_PLUS) || (in_character == CH_MINUS);
    q_wdata.is_minus = (in_character == CH_MINUS);
    if ((in_character >= CH_ZERO) && (in_character <= CH_NINE)) begin
      q_wdata.is_digit = 1'b1;
      q_wdata.dval     = DIGIT_W'(in_character - CH_ZERO);
    end else if ((lower >= CH_LA) && (lower <= CH_LZ)) begin
      q_wdata.is_digit = 1'b1;
      q_wdata.dval     = DIGIT_W'(lower - CH_LA) + DIGIT_W'(10);
    end
    if (lower == CH_LX) begin
      q_wdata.pfx_base = HEX_BASE;
    end else if (lower == CH_LO) begin
      q_wdata.pfx_base = OCT_BASE;
    end else if (lower == CH_LB) begin
      q_wdata.pfx_base = BIN_BASE;
    end else begin
      q_wdata.pfx_base = NO_PFX;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

[design/pisp_fifo.sv]
// ----------------------------------------------------------------------------
// pisp_fifo: short queue between classifier and parser
// A small show-ahead queue of classified beats.
// ----------------------------------------------------------------------------
module pisp_fifo import pisp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t wdata,
  input  logic pop,
  output cls_t rdata,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[design/pisp_back.sv]
// ----------------------------------------------------------------------------
// pisp_back: parse state machine and accumulator
// Takes one queued beat a cycle (a last beat waits for the result stage),
// tracks sign, prefix and base, accumulates the magnitude by one multiply-add.
// ----------------------------------------------------------------------------
module pisp_back import pisp_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BASE_W-1:0] cfg_base,
  input  cls_t              q_rdata,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              snap_ready,
  output logic              snap_load,
  output snap_t             snap_data
);

  localparam int CNT_W = ($clog2(MAX_CHARS + 1) > CONSUMED_W) ?
                         $clog2(MAX_CHARS + 1) : CONSUMED_W;
  localparam int PROD_W = VALUE_W + BASE_W;

  phase_t             phase_r, phase_nxt;
  logic               negative_r, negative_nxt;
  logic [BASE_W-1:0]  active_base_r, active_base_nxt;
  logic [VALUE_W-1:0] magnitude_r, magnitude_nxt;
  logic               overflowed_r, overflowed_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [BASE_W-1:0]  base_cur;
  logic [BASE_W-1:0]  base_eff;
  logic               digit_ok;
  logic               zero_ch;
  logic               pfx_hit;
  logic [PROD_W-1:0]  product;
  logic               take;
  logic               count_one;

  assign q_pop     = !q_empty && (!q_rdata.last || snap_ready);
  assign snap_load = q_pop && q_rdata.last;

  // The base is sampled from the register on the first character.
  assign base_cur = (phase_r == PH_START) ? cfg_base : active_base_r;
  assign base_eff = (base_cur == '0) ? DEC_BASE : base_cur;
  assign digit_ok = q_rdata.is_digit && (q_rdata.dval < base_eff);
  assign zero_ch  = q_rdata.is_digit && (q_rdata.dval == '0);
  assign pfx_hit  = (q_rdata.pfx_base != NO_PFX) &&
                    ((base_cur == '0) || (base_cur == BASE_W'(q_rdata.pfx_base)));
  assign product  = (PROD_W'(magnitude_r) * PROD_W'(base_eff)) + PROD_W'(q_rdata.dval);

  // Next phase, plus which path of the parse this beat takes.
  always_comb begin
    phase_nxt = phase_r;
    take      = 1'b0;
    count_one = 1'b0;
    unique case (phase_r)
      PH_START: begin
        if (q_rdata.is_sign) begin
          phase_nxt = PH_SIGNED;
          count_one = 1'b1;
        end else if (zero_ch) begin
          phase_nxt = PH_ZERO;
          count_one = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      PH_SIGNED: begin
        if (zero_ch) begin
          phase_nxt = PH_ZERO;
          count_one = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      PH_ZERO: begin
        if (pfx_hit) begin
          phase_nxt = PH_DIGITS;
          count_one = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      PH_DIGITS: take = 1'b1;
      PH_DONE:   phase_nxt = PH_DONE;
      default:   phase_nxt = PH_DONE;
    endcase
    if (take) begin
      phase_nxt = digit_ok ? PH_DIGITS : PH_DONE;
      count_one = digit_ok;
    end
  end

  // Datapath updates for the beat.
  always_comb begin
    negative_nxt    = negative_r;
    active_base_nxt = base_cur;
    magnitude_nxt   = magnitude_r;
    overflowed_nxt  = overflowed_r;
    count_nxt       = count_r;
    if ((phase_r == PH_START) && q_rdata.is_sign) begin
      negative_nxt = q_rdata.is_minus;
    end
    if ((phase_r == PH_ZERO) && pfx_hit) begin
      active_base_nxt = BASE_W'(q_rdata.pfx_base);
    end else if (take && (base_cur == '0)) begin
      active_base_nxt = DEC_BASE;
    end
    if (take && digit_ok && !overflowed_r) begin
      if (product[PROD_W-1:VALUE_W] != '0) begin
        overflowed_nxt = 1'b1;
      end else begin
        magnitude_nxt = product[VALUE_W-1:0];
      end
    end
    if (count_one && (count_r < CNT_W'(MAX_CHARS))) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_comb begin
    snap_data.magnitude  = magnitude_nxt;
    snap_data.negative   = negative_nxt;
    snap_data.overflowed = overflowed_nxt;
    snap_data.consumed   = count_nxt[CONSUMED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START;
      negative_r    <= 1'b0;
      active_base_r <= '0;
      magnitude_r   <= '0;
      overflowed_r  <= 1'b0;
      count_r       <= '0;
    end else if (q_pop) begin
      if (q_rdata.last) begin
        phase_r       <= PH_START;
        negative_r    <= 1'b0;
        active_base_r <= '0;
        magnitude_r   <= '0;
        overflowed_r  <= 1'b0;
        count_r       <= '0;
      end else begin
        phase_r       <= phase_nxt;
        negative_r    <= negative_nxt;
        active_base_r <= active_base_nxt;
        magnitude_r   <= magnitude_nxt;
        overflowed_r  <= overflowed_nxt;
        count_r       <= count_nxt;
      end
    end
  end

endmodule

[design/pisp_result.sv]
// ----------------------------------------------------------------------------
// pisp_result: signed range check and output register
// Holds a finished string's state, applies sign and saturation, and
// presents the result beat from its own register.
// ----------------------------------------------------------------------------
module pisp_result import pisp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      snap_load,
  input  snap_t                     snap_data,
  output logic                      snap_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_range_error,
  output logic [CONSUMED_W-1:0]     out_consumed
);

  localparam logic [VALUE_W-1:0] TOP     = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  snap_t                 snap_r;
  logic                  snap_valid_r;
  logic                  out_valid_r;
  logic [VALUE_W-1:0]    value_r, value_nxt;
  logic                  err_r, err_nxt;
  logic [CONSUMED_W-1:0] consumed_r;
  logic                  out_free;
  logic                  move;

  assign out_free   = !out_valid_r || !out_stall;
  assign move       = snap_valid_r && out_free;
  assign snap_ready = !snap_valid_r || out_free;

  always_comb begin
    err_nxt   = snap_r.overflowed;
    value_nxt = snap_r.magnitude;
    if (snap_r.overflowed) begin
      value_nxt = snap_r.negative ? TOP : POS_MAX;
    end else if (snap_r.negative) begin
      if (snap_r.magnitude > TOP) begin
        err_nxt   = 1'b1;
        value_nxt = TOP;
      end else begin
        value_nxt = '0 - snap_r.magnitude;
      end
    end else if (snap_r.magnitude[VALUE_W-1]) begin
      err_nxt   = 1'b1;
      value_nxt = POS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (snap_load) begin
        snap_valid_r <= 1'b1;
      end else if (move) begin
        snap_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_r <= snap_data;
    end
    if (move) begin
      value_r    <= value_nxt;
      err_r      <= err_nxt;
      consumed_r <= snap_r.consumed;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = value_r;
  assign out_range_error = err_r;
  assign out_consumed    = consumed_r;

endmodule

[design/prefixed_integer_string_parser.sv]
// ----------------------------------------------------------------------------
// prefixed_integer_string_parser: streaming signed integer parser
// Parses one string, a character a beat, into a saturated signed 64-bit
// value with a range error flag and a count of consumed characters.
// ----------------------------------------------------------------------------
// Usage. Characters arrive on the input channel (in_valid, in_stall,
// in_character, in_last), one beat per character, and in_last marks the
// final character of a string. Each string gives exactly one result beat on
// the output channel (out_valid, out_stall, out_value, out_range_error,
// out_consumed) when its last character has been taken.
// The radix is written on the configuration channel (cfg_valid, cfg_ready,
// cfg_number_base); zero selects detection from a 0x, 0o or 0b prefix. It
// is sampled on the first character of each string. The user is to write it
// only while the block is idle; the block does not enforce it. cfg_ready is
// always high. Throughput is one character per cycle while in_stall is low,
// set by the single 64 by 6 bit multiply-add in the parser that updates the
// magnitude. Once its last character is accepted, the result of a string
// passes from the queue through the parser into the range-check stage, and
// from there through the range check into the output register.
// Reset clears the parse state, the queue, the pipeline and the radix
// (back to zero). When the receiver stalls, the result holds in the output
// register and a second one waits in the range-check stage; further
// characters fill the two-entry queue before in_stall is raised.
// ----------------------------------------------------------------------------
module prefixed_integer_string_parser import pisp_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [BASE_W-1:0]         cfg_number_base,
  // input channel, one character per beat
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CHAR_W-1:0]         in_character,
  input  logic                      in_last,
  // result channel, one beat per string
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_range_error,
  output logic [CONSUMED_W-1:0]     out_consumed
);

  logic [BASE_W-1:0] number_base_r;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  cls_t              q_wdata;
  cls_t              q_rdata;
  logic              snap_ready;
  logic              snap_load;
  snap_t             snap_data;

  // The radix register takes every write; it has a single address.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      number_base_r <= cfg_number_base;
    end
  end

  // Front end: classify each character and queue it.
  pisp_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .in_last      (in_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // The queue lets the front keep accepting while the back waits on the
  // result stage.
  pisp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back end: sign, prefix, base and the digit accumulator. Only a last
  // character waits for room in the result stage.
  pisp_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_base   (number_base_r),
    .q_rdata    (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .snap_ready (snap_ready),
    .snap_load  (snap_load),
    .snap_data  (snap_data)
  );

  // Range check, saturation and the output register.
  pisp_result u_result (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap_load       (snap_load),
    .snap_data       (snap_data),
    .snap_ready      (snap_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_range_error (out_range_error),
    .out_consumed    (out_consumed)
  );

endmodule
